// File: rtl/core/max_flow_bfs_augment_core_assert.svh
// ----------------------------------------------------------------------------
// max_flow_bfs_augment_core_assert.svh
// Assertion macros used by the max-flow core controller (mfba_ctrl).
// ----------------------------------------------------------------------------
`ifndef MAX_FLOW_BFS_AUGMENT_CORE_ASSERT_SVH
`define MAX_FLOW_BFS_AUGMENT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check sampled on the rising clock, off while reset is asserted
`define MFBA_CHECK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// check sampled on the rising clock, always on
`define MFBA_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MFBA_CHECK(lbl, clk, rstn, prop, msg)
`define MFBA_CHECK_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/mfba_pkg.sv
// ----------------------------------------------------------------------------
// mfba_pkg
// Types and constants of the max-flow (BFS augmenting path) core.
// ----------------------------------------------------------------------------
package mfba_pkg;

    localparam int NODES    = 64;
    localparam int NODE_W   = 6;
    localparam int CNT_W    = NODE_W + 1;
    localparam int ADDR_W   = 2 * NODE_W;
    localparam int CAP_W    = 16;
    localparam int FLOW_W   = CAP_W + 1;
    localparam int RES_W    = CAP_W + 2;
    localparam int OUT_W    = 22;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [OUT_W-1:0]  OUT_MAX = {OUT_W{1'b1}};
    localparam logic [RES_W-1:0]  RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [NODE_W-1:0] SINK_RESET = NODE_W'(NODES - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET   = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BFS_INIT,
        S_POP,
        S_POP_W,
        S_SCAN,
        S_CHECK,
        S_W1_P,
        S_W1_PW,
        S_W1_R,
        S_W1_END,
        S_W2_P,
        S_W2_PW,
        S_W2_R,
        S_W2_B,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] raddr;
        logic [ADDR_W-1:0] waddr;
        logic              cap_we;
        logic [CAP_W-1:0]  cap_wdata;
        logic              flow_we;
        logic [FLOW_W-1:0] flow_wdata;
    } t_graph_req;

    typedef struct packed {
        logic [NODE_W-1:0] par_raddr;
        logic              par_we;
        logic [NODE_W-1:0] par_waddr;
        logic [NODE_W-1:0] par_wdata;
        logic [NODE_W-1:0] q_raddr;
        logic              q_we;
        logic [NODE_W-1:0] q_waddr;
        logic [NODE_W-1:0] q_wdata;
    } t_search_req;

endpackage

// File: rtl/core/mfba_graph_mem.sv
// ----------------------------------------------------------------------------
// mfba_graph_mem
// Capacity and flow matrices, one entry per (tail, head) pair.
// ----------------------------------------------------------------------------
module mfba_graph_mem (
    input  logic                            i_clk,
    input  mfba_pkg::t_graph_req            i_req,
    output logic [mfba_pkg::CAP_W-1:0]      o_cap,
    output logic [mfba_pkg::FLOW_W-1:0]     o_flow
);

    localparam int DEPTH = 1 << mfba_pkg::ADDR_W;

    logic [mfba_pkg::CAP_W-1:0]  cap_mem  [DEPTH];
    logic [mfba_pkg::FLOW_W-1:0] flow_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.cap_we) begin
            cap_mem[i_req.waddr] <= i_req.cap_wdata;
        end
        o_cap <= cap_mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.flow_we) begin
            flow_mem[i_req.waddr] <= i_req.flow_wdata;
        end
        o_flow <= flow_mem[i_req.raddr];
    end

endmodule

// File: rtl/core/mfba_search_mem.sv
// ----------------------------------------------------------------------------
// mfba_search_mem
// Parent table and BFS queue of the search.
// ----------------------------------------------------------------------------
module mfba_search_mem (
    input  logic                            i_clk,
    input  mfba_pkg::t_search_req           i_req,
    output logic [mfba_pkg::NODE_W-1:0]     o_parent,
    output logic [mfba_pkg::NODE_W-1:0]     o_queue
);

    localparam int DEPTH = 1 << mfba_pkg::NODE_W;

    logic [mfba_pkg::NODE_W-1:0] par_mem [DEPTH];
    logic [mfba_pkg::NODE_W-1:0] q_mem   [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.par_we) begin
            par_mem[i_req.par_waddr] <= i_req.par_wdata;
        end
        o_parent <= par_mem[i_req.par_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.q_we) begin
            q_mem[i_req.q_waddr] <= i_req.q_wdata;
        end
        o_queue <= q_mem[i_req.q_raddr];
    end

endmodule

// File: rtl/core/mfba_ctrl.sv
// ----------------------------------------------------------------------------
// mfba_ctrl
// Sequencer: clearing sweep, capacity writes, BFS scan, bottleneck walk and
// flow update along the parent path.
// ----------------------------------------------------------------------------
`include "max_flow_bfs_augment_core_assert.svh"

module mfba_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mfba_pkg::MODE_W-1:0]     i_mode,
    input  logic [mfba_pkg::NODE_W-1:0]     i_from_node,
    input  logic [mfba_pkg::NODE_W-1:0]     i_to_node,
    input  logic [mfba_pkg::CAP_W-1:0]      i_capacity,
    input  logic [mfba_pkg::NODE_W-1:0]     i_src,
    input  logic [mfba_pkg::NODE_W-1:0]     i_snk,
    input  logic                            i_out_busy,
    output logic                            o_done,
    output logic [mfba_pkg::OUT_W-1:0]      o_total,
    output mfba_pkg::t_graph_req            o_greq,
    input  logic [mfba_pkg::CAP_W-1:0]      i_g_cap,
    input  logic [mfba_pkg::FLOW_W-1:0]     i_g_flow,
    output mfba_pkg::t_search_req           o_sreq,
    input  logic [mfba_pkg::NODE_W-1:0]     i_parent,
    input  logic [mfba_pkg::NODE_W-1:0]     i_queue
);

    localparam int NW = mfba_pkg::NODE_W;

    mfba_pkg::t_state                 r_state, n_state;
    logic [mfba_pkg::ADDR_W-1:0]      r_clr, n_clr;
    logic [NW-1:0]                    r_x, n_x;
    logic [mfba_pkg::CNT_W-1:0]       r_y, n_y;
    logic                             r_iss, n_iss;
    logic [NW-1:0]                    r_yd, n_yd;
    logic [mfba_pkg::CNT_W-1:0]       r_head, n_head;
    logic [mfba_pkg::CNT_W-1:0]       r_tail, n_tail;
    logic [mfba_pkg::NODES-1:0]       r_seen, n_seen;
    logic [NW-1:0]                    r_i, n_i;
    logic [NW-1:0]                    r_p, n_p;
    logic signed [mfba_pkg::RES_W-1:0] r_bn, n_bn;
    logic [mfba_pkg::OUT_W-1:0]       r_total, n_total;
    logic [mfba_pkg::FLOW_W-1:0]      r_new, n_new;

    logic signed [mfba_pkg::RES_W-1:0] res;
    logic [mfba_pkg::RES_W-1:0]       flow_sum;
    logic [mfba_pkg::OUT_W:0]         tot_sum;

    // residual of the entry read in the previous cycle
    assign res = $signed({2'b00, i_g_cap}) - $signed({i_g_flow[mfba_pkg::FLOW_W-1], i_g_flow});
    assign flow_sum = {i_g_flow[mfba_pkg::FLOW_W-1], i_g_flow} + r_bn;
    assign tot_sum  = {1'b0, r_total} + (mfba_pkg::OUT_W+1)'(r_bn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfba_pkg::S_CLEAR;
            r_clr   <= '0;
            r_iss   <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
            r_seen  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_iss   <= n_iss;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_seen  <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_yd    <= n_yd;
        r_i     <= n_i;
        r_p     <= n_p;
        r_bn    <= n_bn;
        r_total <= n_total;
        r_new   <= n_new;
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_x     = r_x;
        n_y     = r_y;
        n_iss   = r_iss;
        n_yd    = r_yd;
        n_head  = r_head;
        n_tail  = r_tail;
        n_seen  = r_seen;
        n_i     = r_i;
        n_p     = r_p;
        n_bn    = r_bn;
        n_total = r_total;
        n_new   = r_new;
        o_done  = 1'b0;
        o_greq  = '0;
        o_sreq  = '0;
        o_greq.raddr = {r_x, r_y[NW-1:0]};

        unique case (r_state)
            mfba_pkg::S_CLEAR: begin
                o_greq.waddr   = r_clr;
                o_greq.cap_we  = 1'b1;
                o_greq.flow_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = mfba_pkg::S_IDLE;
                end
            end
            mfba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (mfba_pkg::t_mode'(i_mode))
                        mfba_pkg::MODE_SET: begin
                            o_greq.waddr     = {i_from_node, i_to_node};
                            o_greq.cap_we    = 1'b1;
                            o_greq.cap_wdata = i_capacity;
                        end
                        mfba_pkg::MODE_CLEAR: begin
                            n_clr   = '0;
                            n_state = mfba_pkg::S_CLEAR;
                        end
                        mfba_pkg::MODE_RUN: begin
                            n_total = '0;
                            n_state = (i_src == i_snk) ? mfba_pkg::S_DONE
                                                       : mfba_pkg::S_BFS_INIT;
                        end
                        mfba_pkg::MODE_NONE: begin
                        end
                    endcase
                end
            end
            mfba_pkg::S_BFS_INIT: begin
                n_seen = '0;
                n_seen[i_src] = 1'b1;
                o_sreq.q_we    = 1'b1;
                o_sreq.q_waddr = '0;
                o_sreq.q_wdata = i_src;
                n_head  = '0;
                n_tail  = mfba_pkg::CNT_W'(1);
                n_state = mfba_pkg::S_POP;
            end
            mfba_pkg::S_POP: begin
                if (r_head == r_tail) begin
                    n_state = mfba_pkg::S_CHECK;
                end else begin
                    o_sreq.q_raddr = r_head[NW-1:0];
                    n_head  = r_head + 1'b1;
                    n_state = mfba_pkg::S_POP_W;
                end
            end
            mfba_pkg::S_POP_W: begin
                n_x     = i_queue;
                n_y     = '0;
                n_iss   = 1'b0;
                n_state = mfba_pkg::S_SCAN;
            end
            mfba_pkg::S_SCAN: begin
                // issue one neighbor a cycle, judge it when its entry returns
                if (!r_y[NW]) begin
                    o_greq.raddr = {r_x, r_y[NW-1:0]};
                    n_iss = 1'b1;
                    n_yd  = r_y[NW-1:0];
                    n_y   = r_y + 1'b1;
                end else begin
                    n_iss = 1'b0;
                end
                if (r_iss && !r_seen[r_yd] && (res > 0)) begin
                    n_seen[r_yd]     = 1'b1;
                    o_sreq.par_we    = 1'b1;
                    o_sreq.par_waddr = r_yd;
                    o_sreq.par_wdata = r_x;
                    if (!r_tail[NW]) begin
                        o_sreq.q_we    = 1'b1;
                        o_sreq.q_waddr = r_tail[NW-1:0];
                        o_sreq.q_wdata = r_yd;
                        n_tail = r_tail + 1'b1;
                    end
                end
                if (r_y[NW] && !r_iss) begin
                    n_state = mfba_pkg::S_POP;
                end
            end
            mfba_pkg::S_CHECK: begin
                if (r_seen[i_snk]) begin
                    n_i     = i_snk;
                    n_bn    = mfba_pkg::RES_MAX;
                    n_state = mfba_pkg::S_W1_P;
                end else begin
                    n_state = mfba_pkg::S_DONE;
                end
            end
            mfba_pkg::S_W1_P: begin
                if (r_i == i_src) begin
                    n_state = mfba_pkg::S_W1_END;
                end else begin
                    o_sreq.par_raddr = r_i;
                    n_state = mfba_pkg::S_W1_PW;
                end
            end
            mfba_pkg::S_W1_PW: begin
                n_p = i_parent;
                o_greq.raddr = {i_parent, r_i};
                n_state = mfba_pkg::S_W1_R;
            end
            mfba_pkg::S_W1_R: begin
                if (res < r_bn) begin
                    n_bn = res;
                end
                n_i     = r_p;
                n_state = mfba_pkg::S_W1_P;
            end
            mfba_pkg::S_W1_END: begin
                if (r_bn <= 0) begin
                    n_state = mfba_pkg::S_DONE;
                end else begin
                    n_i     = i_snk;
                    n_state = mfba_pkg::S_W2_P;
                end
            end
            mfba_pkg::S_W2_P: begin
                if (r_i == i_src) begin
                    n_total = (tot_sum > {1'b0, mfba_pkg::OUT_MAX}) ? mfba_pkg::OUT_MAX
                                                                   : tot_sum[mfba_pkg::OUT_W-1:0];
                    n_state = mfba_pkg::S_BFS_INIT;
                end else begin
                    o_sreq.par_raddr = r_i;
                    n_state = mfba_pkg::S_W2_PW;
                end
            end
            mfba_pkg::S_W2_PW: begin
                n_p = i_parent;
                o_greq.raddr = {i_parent, r_i};
                n_state = mfba_pkg::S_W2_R;
            end
            mfba_pkg::S_W2_R: begin
                o_greq.waddr      = {r_p, r_i};
                o_greq.flow_we    = 1'b1;
                o_greq.flow_wdata = flow_sum[mfba_pkg::FLOW_W-1:0];
                n_new   = flow_sum[mfba_pkg::FLOW_W-1:0];
                n_state = mfba_pkg::S_W2_B;
            end
            mfba_pkg::S_W2_B: begin
                // flow stays antisymmetric: reverse entry is the negation
                o_greq.waddr      = {r_i, r_p};
                o_greq.flow_we    = 1'b1;
                o_greq.flow_wdata = -r_new;
                n_i     = r_p;
                n_state = mfba_pkg::S_W2_P;
            end
            mfba_pkg::S_DONE: begin
                if (!i_out_busy) begin
                    o_done  = 1'b1;
                    n_state = mfba_pkg::S_IDLE;
                end
            end
        endcase
    end

    assign o_in_stall = (r_state != mfba_pkg::S_IDLE);
    assign o_total    = r_total;

    `MFBA_CHECK(a_tail_bound, i_clk, i_rst_n, r_tail <= mfba_pkg::CNT_W'(mfba_pkg::NODES), "queue tail past node count")
    `MFBA_CHECK(a_head_le_tail, i_clk, i_rst_n, (r_state == mfba_pkg::S_POP) |-> (r_head <= r_tail), "queue head passed tail")
    `MFBA_CHECK(a_bn_positive, i_clk, i_rst_n, (r_state == mfba_pkg::S_W2_P) |-> (r_bn > 0), "augment with non-positive bottleneck")

endmodule

// File: rtl/core/max_flow_bfs_augment_core.sv
// Set-capacity word: one word per cycle while the core is idle. Clear word:
// sweep of all 4096 entries. Run word: per BFS round a pop, 64 neighbor reads
// and a drain per reached node, plus bottleneck and flow-update steps per path
// edge, until sink is cut. Result sits in an output register; the next word is
// taken once the run ends. Reset (synchronous, active low) clears the capacity
// and flow memories; input is stalled meanwhile, config is taken.
// ----------------------------------------------------------------------------
// max_flow_bfs_augment_core
// Edmonds-Karp max-flow engine over a memory-held capacity/flow matrix.
// ----------------------------------------------------------------------------
module max_flow_bfs_augment_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mfba_pkg::MODE_W-1:0]         i_mode,
    input  logic [mfba_pkg::NODE_W-1:0]         i_from_node,
    input  logic [mfba_pkg::NODE_W-1:0]         i_to_node,
    input  logic [mfba_pkg::CAP_W-1:0]          i_capacity,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mfba_pkg::OUT_W-1:0]          o_max_flow,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mfba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mfba_pkg::NODE_W-1:0]         i_cfg_data
);

    logic [mfba_pkg::NODE_W-1:0]  r_src;
    logic [mfba_pkg::NODE_W-1:0]  r_snk;
    logic                         r_out_valid;
    logic [mfba_pkg::OUT_W-1:0]   r_out_data;

    logic                         done;
    logic [mfba_pkg::OUT_W-1:0]   total;
    mfba_pkg::t_graph_req         greq;
    mfba_pkg::t_search_req        sreq;
    logic [mfba_pkg::CAP_W-1:0]   g_cap;
    logic [mfba_pkg::FLOW_W-1:0]  g_flow;
    logic [mfba_pkg::NODE_W-1:0]  parent;
    logic [mfba_pkg::NODE_W-1:0]  queue_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= '0;
            r_snk <= mfba_pkg::SINK_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mfba_pkg::CFG_SOURCE: r_src <= i_cfg_data;
                mfba_pkg::CFG_SINK:   r_snk <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_max_flow  = r_out_data;

    mfba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_from_node (i_from_node),
        .i_to_node   (i_to_node),
        .i_capacity  (i_capacity),
        .i_src       (r_src),
        .i_snk       (r_snk),
        .i_out_busy  (r_out_valid & i_out_stall),
        .o_done      (done),
        .o_total     (total),
        .o_greq      (greq),
        .i_g_cap     (g_cap),
        .i_g_flow    (g_flow),
        .o_sreq      (sreq),
        .i_parent    (parent),
        .i_queue     (queue_head)
    );

    mfba_graph_mem u_graph (
        .i_clk  (i_clk),
        .i_req  (greq),
        .o_cap  (g_cap),
        .o_flow (g_flow)
    );

    mfba_search_mem u_search (
        .i_clk    (i_clk),
        .i_req    (sreq),
        .o_parent (parent),
        .o_queue  (queue_head)
    );

endmodule

// File: tb/max_flow_bfs_augment_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_flow_bfs_augment_core_test
// Self-checking bench for the max-flow core: streams capacity loads, clears
// and flow runs over directed cases and small random graphs, predicts every run total
// with an in-bench Edmonds-Karp model and compares it with each result word.
// ----------------------------------------------------------------------------
module max_flow_bfs_augment_core_test;

    localparam int  LIMIT_CYCLES = 6000000;
    localparam int  SETTLE       = 5000;   // covers a clear sweep still running

    typedef struct {
        mfba_pkg::t_mode                 mode;
        logic [mfba_pkg::NODE_W-1:0]     from_node;
        logic [mfba_pkg::NODE_W-1:0]     to_node;
        logic [mfba_pkg::CAP_W-1:0]      capacity;
    } t_word;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic [mfba_pkg::MODE_W-1:0]       i_mode;
    logic [mfba_pkg::NODE_W-1:0]       i_from_node;
    logic [mfba_pkg::NODE_W-1:0]       i_to_node;
    logic [mfba_pkg::CAP_W-1:0]        i_capacity;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [mfba_pkg::OUT_W-1:0]        o_max_flow;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [mfba_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [mfba_pkg::NODE_W-1:0]       i_cfg_data;

    max_flow_bfs_augment_core dut (.*);

    always #5 i_clk = ~i_clk;

    // model state
    logic [mfba_pkg::CAP_W-1:0]  cap_mat [mfba_pkg::NODES][mfba_pkg::NODES];
    int                          flow_mat[mfba_pkg::NODES][mfba_pkg::NODES];
    int                          parent  [mfba_pkg::NODES];
    logic [mfba_pkg::NODE_W-1:0] src_node, snk_node;

    t_word                       pending[$];
    logic [mfba_pkg::OUT_W-1:0]  flow_totals[$];
    t_word                       cur_word;
    bit                          word_taken, quiet;
    int                          in_gap, out_gap;
    int                          fails, cycles, n_runs, n_loads, n_clears, n_saturated;

    function automatic int resid(int a, int b);
        return int'(cap_mat[a][b]) - flow_mat[a][b];
    endfunction

    // breadth-first search, neighbors in ascending order
    function automatic bit find_path(int s, int t);
        bit seen[mfba_pkg::NODES];
        int q[mfba_pkg::NODES];
        int head, tail, x;
        head = 0;
        tail = 0;
        foreach (seen[k]) begin
            seen[k] = 1'b0;
            parent[k] = 0;
        end
        seen[s] = 1'b1;
        q[tail++] = s;
        while (head < tail) begin
            x = q[head++];
            for (int y = 0; y < mfba_pkg::NODES; y++) begin
                if (seen[y] || resid(x, y) <= 0) continue;
                seen[y] = 1'b1;
                parent[y] = x;
                if (tail < mfba_pkg::NODES) q[tail++] = y;
            end
        end
        return seen[t];
    endfunction

    function automatic longint run_max_flow(int s, int t);
        longint total;
        int     bn, r, i, p, steps;
        total = 0;
        while (find_path(s, t)) begin
            bn = resid(parent[t], t);
            i = t;
            steps = 0;
            while (i != s && steps < mfba_pkg::NODES) begin
                r = resid(parent[i], i);
                if (r < bn) bn = r;
                i = parent[i];
                steps++;
            end
            if (bn <= 0) break;
            i = t;
            steps = 0;
            while (i != s && steps < mfba_pkg::NODES) begin
                p = parent[i];
                flow_mat[p][i] += bn;
                flow_mat[i][p] -= bn;
                i = p;
                steps++;
            end
            total += bn;
        end
        return total;
    endfunction

    task automatic apply_word(t_word w);
        longint total;
        case (w.mode)
            mfba_pkg::MODE_SET: begin
                cap_mat[w.from_node][w.to_node] = w.capacity;
                n_loads++;
            end
            mfba_pkg::MODE_CLEAR: begin
                foreach (cap_mat[a, b]) begin
                    cap_mat[a][b] = '0;
                    flow_mat[a][b] = 0;
                end
                n_clears++;
            end
            mfba_pkg::MODE_RUN: begin
                total = 0;
                if (src_node != snk_node) total = run_max_flow(src_node, snk_node);
                if (total > longint'(mfba_pkg::OUT_MAX)) begin
                    total = mfba_pkg::OUT_MAX;
                    n_saturated++;
                end
                flow_totals.insert(flow_totals.size(), mfba_pkg::OUT_W'(total));
                n_runs++;
            end
            default: ;
        endcase
    endtask

    function automatic t_word mk(mfba_pkg::t_mode m, int a, int b, int c);
        t_word w;
        w.mode = m;
        w.from_node = mfba_pkg::NODE_W'(a);
        w.to_node = mfba_pkg::NODE_W'(b);
        w.capacity = mfba_pkg::CAP_W'(c);
        return w;
    endfunction

    function automatic void add_word(t_word w);
        pending.insert(pending.size(), w);
    endfunction

    // input side: accept at rising edge, drive at falling edge
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results outstanding", $time, flow_totals.size());
            $display("** max_flow_bfs_augment_core: FAILED **");
            $finish;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            apply_word(cur_word);
            word_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        logic nxt_valid;
        t_word w;
        nxt_valid = i_in_valid;
        if (i_rst_n && (!i_in_valid || word_taken)) begin
            nxt_valid = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending.size() > 0 && !quiet && $urandom_range(0, 19) == 0) begin
                in_gap = $urandom_range(1, 11) - 1;
            end else if (pending.size() > 0) begin
                w = pending.pop_front();
                cur_word = w;
                i_mode <= w.mode;
                i_from_node <= w.from_node;
                i_to_node <= w.to_node;
                i_capacity <= w.capacity;
                nxt_valid = 1'b1;
            end
        end
        word_taken = 1'b0;
        i_in_valid <= nxt_valid;
    end

    // result side
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            out_gap = $urandom_range(1, 11) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        logic [mfba_pkg::OUT_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (flow_totals.size() == 0) begin
                $display("%0t: unexpected result word, max_flow=%0d", $time, o_max_flow);
                fails++;
            end else begin
                want = flow_totals.pop_front();
                if (o_max_flow !== want) begin
                    $display("%0t: max_flow mismatch, expected %0d, actual %0d",
                             $time, want, o_max_flow);
                    fails++;
                end
            end
        end
    end

    task automatic write_reg(logic [mfba_pkg::CFG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= mfba_pkg::NODE_W'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == mfba_pkg::CFG_SOURCE) src_node = mfba_pkg::NODE_W'(val);
        else snk_node = mfba_pkg::NODE_W'(val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() != 0 || i_in_valid || flow_totals.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // one random graph then a run; most of the graph sits on a small node set
    task automatic push_graph_run();
        int pool[8];
        int np, ne, a, b, c;
        np = $urandom_range(3, 8);
        pool[0] = src_node;
        pool[1] = snk_node;
        for (int k = 2; k < np; k++) pool[k] = $urandom_range(0, mfba_pkg::NODES - 1);
        if ($urandom_range(0, 9) == 0) pool[0] = $urandom_range(0, mfba_pkg::NODES - 1);
        if ($urandom_range(0, 3) == 0) add_word(mk(mfba_pkg::MODE_CLEAR, 0, 0, 0));
        ne = $urandom_range(2, 12);
        for (int k = 0; k < ne; k++) begin
            a = pool[$urandom_range(0, np - 1)];
            b = pool[$urandom_range(0, np - 1)];
            case ($urandom_range(0, 3))
                0: c = $urandom_range(0, 65535);
                1: c = 65535;
                default: c = $urandom_range(0, 20);
            endcase
            add_word(mk(mfba_pkg::MODE_SET, a, b, c));
        end
        // noise: stray edge or unused mode
        if ($urandom_range(0, 4) == 0)
            add_word(mk(mfba_pkg::MODE_SET, $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 65535)));
        if ($urandom_range(0, 7) == 0)
            add_word(mk(mfba_pkg::MODE_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 65535)));
        add_word(mk(mfba_pkg::MODE_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 65535)));
        if ($urandom_range(0, 5) == 0) add_word(mk(mfba_pkg::MODE_RUN, 0, 0, 0));
    endtask

    task automatic random_phase(int n_words);
        int target;
        target = pending.size() + n_words;
        while (pending.size() < target) push_graph_run();
        drain();
    endtask

    initial begin
        foreach (cap_mat[a, b]) begin
            cap_mat[a][b] = '0;
            flow_mat[a][b] = 0;
        end
        src_node = '0;
        snk_node = mfba_pkg::SINK_RESET;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = mfba_pkg::MODE_NONE;
        i_from_node = '0;
        i_to_node = '0;
        i_capacity = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = mfba_pkg::CFG_SOURCE;
        i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: direct edge, rerun, self edge, unused mode, capacity cut under flow
        add_word(mk(mfba_pkg::MODE_RUN, 0, 0, 0));
        add_word(mk(mfba_pkg::MODE_SET, 0, 63, 65535));
        add_word(mk(mfba_pkg::MODE_RUN, 63, 63, 65535));
        add_word(mk(mfba_pkg::MODE_RUN, 0, 0, 0));
        add_word(mk(mfba_pkg::MODE_SET, 5, 5, 100));
        add_word(mk(mfba_pkg::MODE_NONE, 63, 63, 65535));
        add_word(mk(mfba_pkg::MODE_SET, 0, 1, 1));
        add_word(mk(mfba_pkg::MODE_SET, 1, 63, 65535));
        add_word(mk(mfba_pkg::MODE_SET, 0, 2, 10));
        add_word(mk(mfba_pkg::MODE_SET, 2, 1, 5));
        add_word(mk(mfba_pkg::MODE_SET, 0, 5, 7));
        add_word(mk(mfba_pkg::MODE_SET, 5, 63, 3));
        add_word(mk(mfba_pkg::MODE_RUN, 0, 0, 0));
        add_word(mk(mfba_pkg::MODE_SET, 0, 63, 0));
        add_word(mk(mfba_pkg::MODE_SET, 1, 63, 0));
        add_word(mk(mfba_pkg::MODE_RUN, 0, 0, 0));
        add_word(mk(mfba_pkg::MODE_SET, 0, 63, 65535));
        add_word(mk(mfba_pkg::MODE_RUN, 0, 0, 0));
        add_word(mk(mfba_pkg::MODE_CLEAR, 0, 0, 0));
        add_word(mk(mfba_pkg::MODE_RUN, 0, 0, 0));
        drain();

        // equal terminals give zero and touch nothing
        write_reg(mfba_pkg::CFG_SOURCE, 9);
        write_reg(mfba_pkg::CFG_SINK, 9);
        add_word(mk(mfba_pkg::MODE_SET, 9, 10, 50));
        add_word(mk(mfba_pkg::MODE_SET, 10, 9, 50));
        add_word(mk(mfba_pkg::MODE_RUN, 0, 0, 0));
        drain();

        write_reg(mfba_pkg::CFG_SOURCE, 63);
        write_reg(mfba_pkg::CFG_SINK, 0);
        random_phase(250);
        write_reg(mfba_pkg::CFG_SOURCE, $urandom_range(0, 63));
        write_reg(mfba_pkg::CFG_SINK, $urandom_range(0, 63));
        random_phase(250);
        write_reg(mfba_pkg::CFG_SOURCE, 0);
        write_reg(mfba_pkg::CFG_SINK, 63);
        random_phase(250);
        write_reg(mfba_pkg::CFG_SOURCE, $urandom_range(0, 31));
        write_reg(mfba_pkg::CFG_SINK, $urandom_range(32, 63));
        random_phase(250);
        quiet = 1'b1;
        random_phase(150);

        $display("covered %0d capacity loads, %0d clears, %0d flow runs (%0d saturated)",
                 n_loads, n_clears, n_runs, n_saturated);
        if (fails == 0) begin
            $display("** max_flow_bfs_augment_core: PASSED **");
        end else begin
            $display("%0d mismatches", fails);
            $display("** max_flow_bfs_augment_core: FAILED **");
        end
        $finish;
    end

endmodule
